[design/ted_pkg.sv]
// shared types, constants and helpers for the terminal escape and mouse decoder
// no dependencies
package ted_pkg;

	// field widths of the sgr accumulators
	localparam int COORD_WIDTH  = 16;
	localparam int BUTTON_WIDTH = 8;

	localparam int BYTE_W     = 8;
	localparam int TIME_W     = 32;
	localparam int INTERVAL_W = 16;
	localparam int CODE_W     = 10;
	localparam int OUT_BTN_W  = 8;
	localparam int OUT_XY_W   = 16;

	localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = INTERVAL_W'(16);

	// byte values
	localparam logic [BYTE_W-1:0] CH_NUL    = 8'h00;
	localparam logic [BYTE_W-1:0] CH_ESC    = 8'h1b;
	localparam logic [BYTE_W-1:0] CH_LBRACK = 8'h5b;
	localparam logic [BYTE_W-1:0] CH_LT     = 8'h3c;
	localparam logic [BYTE_W-1:0] CH_SEMI   = 8'h3b;
	localparam logic [BYTE_W-1:0] CH_UP     = 8'h41;
	localparam logic [BYTE_W-1:0] CH_DOWN   = 8'h42;
	localparam logic [BYTE_W-1:0] CH_RIGHT  = 8'h43;
	localparam logic [BYTE_W-1:0] CH_LEFT   = 8'h44;
	localparam logic [BYTE_W-1:0] CH_PRESS  = 8'h4d;
	localparam logic [BYTE_W-1:0] CH_REL    = 8'h6d;
	localparam logic [BYTE_W-1:0] CH_ZERO   = 8'h30;
	localparam logic [BYTE_W-1:0] CH_NINE   = 8'h39;

	// key codes
	localparam logic [CODE_W-1:0] KEY_ESC   = 10'd27;
	localparam logic [CODE_W-1:0] KEY_LEFT  = 10'd1000;
	localparam logic [CODE_W-1:0] KEY_RIGHT = 10'd1001;
	localparam logic [CODE_W-1:0] KEY_UP    = 10'd1002;
	localparam logic [CODE_W-1:0] KEY_DOWN  = 10'd1003;

	localparam logic KIND_KEY   = 1'b0;
	localparam logic KIND_MOUSE = 1'b1;

	// one decoded event word
	typedef struct packed {
		logic                 kind;
		logic [CODE_W-1:0]    code;
		logic [OUT_BTN_W-1:0] button;
		logic [OUT_XY_W-1:0]  x;
		logic [OUT_XY_W-1:0]  y;
	} ted_event_t;

	// acc * 10 + d, saturating at the button width
	function automatic logic [BUTTON_WIDTH-1:0] sat_btn(
		input logic [BUTTON_WIDTH-1:0] acc,
		input logic [3:0]              d
	);
		logic [BUTTON_WIDTH+3:0] v;
		v = ({4'b0, acc} << 3) + ({4'b0, acc} << 1) + {{BUTTON_WIDTH{1'b0}}, d};
		if (v[BUTTON_WIDTH+3:BUTTON_WIDTH] != 4'b0) begin
			return {BUTTON_WIDTH{1'b1}};
		end
		return v[BUTTON_WIDTH-1:0];
	endfunction

	// acc * 10 + d, saturating at the coordinate width
	function automatic logic [COORD_WIDTH-1:0] sat_coord(
		input logic [COORD_WIDTH-1:0] acc,
		input logic [3:0]             d
	);
		logic [COORD_WIDTH+3:0] v;
		v = ({4'b0, acc} << 3) + ({4'b0, acc} << 1) + {{COORD_WIDTH{1'b0}}, d};
		if (v[COORD_WIDTH+3:COORD_WIDTH] != 4'b0) begin
			return {COORD_WIDTH{1'b1}};
		end
		return v[COORD_WIDTH-1:0];
	endfunction

endpackage

[design/ted_decode.sv]
// parser state, sgr accumulators and report filter; decodes one byte per step
// depends on ted_pkg
module ted_decode import ted_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  step,
	input  logic [BYTE_W-1:0]     rx_byte,
	input  logic [TIME_W-1:0]     now_ms,
	input  logic                  blocked,
	input  logic [INTERVAL_W-1:0] interval,
	output logic                  emit,
	output ted_event_t            ev
);

	localparam logic [2:0] PH_IDLE    = 3'd0;
	localparam logic [2:0] PH_ESC1    = 3'd1;
	localparam logic [2:0] PH_ESC2_BR = 3'd2;
	localparam logic [2:0] PH_ESC2_NB = 3'd3;
	localparam logic [2:0] PH_BTN     = 3'd4;
	localparam logic [2:0] PH_X       = 3'd5;
	localparam logic [2:0] PH_Y       = 3'd6;

	logic [2:0]              phase_q, phase_d;
	logic [BUTTON_WIDTH-1:0] btn_q, btn_d, last_btn_q;
	logic [COORD_WIDTH-1:0]  x_q, x_d, y_q, y_d, last_x_q, last_y_q;
	logic                    last_valid_q;
	logic [TIME_W-1:0]       last_ms_q;
	logic                    mouse_sent;
	logic                    is_digit;
	logic [3:0]              digit;
	logic [TIME_W-1:0]       elapsed;
	logic                    send_ok;

	assign is_digit = (rx_byte >= CH_ZERO) && (rx_byte <= CH_NINE);
	assign digit    = 4'(rx_byte - CH_ZERO);

	// report filter on the finished accumulators
	assign elapsed = now_ms - last_ms_q;
	always_comb begin
		send_ok = 1'b1;
		if (last_valid_q && (btn_q == last_btn_q)) begin
			if ((x_q == last_x_q) && (y_q == last_y_q)) begin
				send_ok = 1'b0;
			end else if (elapsed < {{(TIME_W-INTERVAL_W){1'b0}}, interval}) begin
				send_ok = 1'b0;
			end
		end
	end

	// next phase, accumulators and event
	always_comb begin
		phase_d    = phase_q;
		btn_d      = btn_q;
		x_d        = x_q;
		y_d        = y_q;
		emit       = 1'b0;
		mouse_sent = 1'b0;
		ev         = '0;
		ev.kind    = KIND_KEY;
		unique case (phase_q)
			PH_ESC1: begin
				phase_d = (rx_byte == CH_LBRACK) ? PH_ESC2_BR : PH_ESC2_NB;
			end
			PH_ESC2_BR: begin
				phase_d = PH_IDLE;
				if (rx_byte == CH_LT) begin
					btn_d   = '0;
					x_d     = '0;
					y_d     = '0;
					phase_d = PH_BTN;
				end else begin
					emit = !blocked;
					unique case (rx_byte)
						CH_UP:    ev.code = KEY_UP;
						CH_DOWN:  ev.code = KEY_DOWN;
						CH_RIGHT: ev.code = KEY_RIGHT;
						CH_LEFT:  ev.code = KEY_LEFT;
						default:  ev.code = KEY_ESC;
					endcase
				end
			end
			PH_ESC2_NB: begin
				phase_d = PH_IDLE;
				emit    = !blocked;
				ev.code = KEY_ESC;
			end
			PH_BTN: begin
				if (rx_byte == CH_SEMI) begin
					phase_d = PH_X;
				end else if (is_digit) begin
					btn_d = sat_btn(btn_q, digit);
				end
			end
			PH_X: begin
				if (rx_byte == CH_SEMI) begin
					phase_d = PH_Y;
				end else if (is_digit) begin
					x_d = sat_coord(x_q, digit);
				end
			end
			PH_Y: begin
				if ((rx_byte == CH_PRESS) || (rx_byte == CH_REL)) begin
					phase_d    = PH_IDLE;
					mouse_sent = !blocked && send_ok;
					emit       = mouse_sent;
					ev.kind    = KIND_MOUSE;
					ev.button  = OUT_BTN_W'(btn_q);
					ev.x       = OUT_XY_W'(x_q);
					ev.y       = OUT_XY_W'(y_q);
				end else if (is_digit) begin
					y_d = sat_coord(y_q, digit);
				end
			end
			default: begin
				phase_d = PH_IDLE;
				if (rx_byte == CH_ESC) begin
					phase_d = PH_ESC1;
				end else if (rx_byte != CH_NUL) begin
					emit    = !blocked;
					ev.code = {{(CODE_W-BYTE_W){1'b0}}, rx_byte};
				end
			end
		endcase
	end

	// parser and last-report state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_IDLE;
			btn_q        <= '0;
			x_q          <= '0;
			y_q          <= '0;
			last_btn_q   <= '0;
			last_x_q     <= '0;
			last_y_q     <= '0;
			last_valid_q <= 1'b0;
			last_ms_q    <= '0;
		end else if (step) begin
			phase_q <= phase_d;
			btn_q   <= btn_d;
			x_q     <= x_d;
			y_q     <= y_d;
			if (mouse_sent) begin
				last_btn_q   <= btn_q;
				last_x_q     <= x_q;
				last_y_q     <= y_q;
				last_valid_q <= 1'b1;
				last_ms_q    <= now_ms;
			end
		end
	end

endmodule

[design/ted_out_reg.sv]
// output register holding one decoded event word until the receiver takes it
// depends on ted_pkg
module ted_out_reg import ted_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  ted_event_t push_ev,
	output logic       space,
	output logic       out_valid,
	input  logic       out_ready,
	output ted_event_t out_ev
);

	logic       valid_q;
	ted_event_t ev_q;

	// slot is free when empty or being drained this cycle
	assign space     = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign out_ev    = ev_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (space) begin
			valid_q <= push;
		end
	end

	always_ff @(posedge clk) begin
		if (space && push) begin
			ev_q <= push_ev;
		end
	end

endmodule

[design/terminal_escape_and_mouse_decoder_unit.sv]
// top level of the terminal escape and sgr mouse decoder
// depends on ted_pkg, ted_decode and ted_out_reg
//
// Usage: bytes from the terminal arrive on the input channel (in_valid/in_ready)
// with a millisecond timestamp and a focus flag. Each word yields zero or one
// event on the output channel (out_valid/out_ready): a key (plain byte, ESC,
// arrows 1000-1003) or an sgr 1006 mouse report, filtered by button change and
// the minimum move interval.
// Throughput: one byte per cycle while the output is not stalled; the single parser
// state update per byte sets this figure.
// Path: an accepted byte is held in the input register, then decoded into the
// output register once that register has space.
// The min move interval is written on the cfg channel (cfg_valid/cfg_data),
// which is always ready; write it only while the block is idle.
// Reset: parser goes idle, accumulators and last report clear, no report is
// counted as sent, interval returns to 16 ms. Both registers empty.
// Stall: while out_ready is low and an event waits, the input register holds
// its byte and in_ready drops once that register is full; nothing is lost.
module terminal_escape_and_mouse_decoder_unit import ted_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [BYTE_W-1:0]     rx_byte,
	input  logic [TIME_W-1:0]     now_ms,
	input  logic                  focus_elsewhere,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [INTERVAL_W-1:0] cfg_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic                  event_kind,
	output logic [CODE_W-1:0]     key_code,
	output logic [OUT_BTN_W-1:0]  mouse_button,
	output logic [OUT_XY_W-1:0]   mouse_x,
	output logic [OUT_XY_W-1:0]   mouse_y
);

	logic                  valid_s1;
	logic [BYTE_W-1:0]     byte_s1;
	logic [TIME_W-1:0]     now_s1;
	logic                  focus_s1;
	logic [INTERVAL_W-1:0] interval_q;
	logic                  space;
	logic                  step;
	logic                  emit;
	logic                  push;
	ted_event_t            dec_ev;
	ted_event_t            out_ev;

	// config register
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			interval_q <= INTERVAL_RESET;
		end else if (cfg_valid && cfg_ready) begin
			interval_q <= cfg_data;
		end
	end

	// input register
	assign step     = valid_s1 && space;
	assign in_ready = !valid_s1 || space;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1  <= rx_byte;
			now_s1   <= now_ms;
			focus_s1 <= focus_elsewhere;
		end
	end

	// decode
	ted_decode u_decode (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (step),
		.rx_byte  (byte_s1),
		.now_ms   (now_s1),
		.blocked  (focus_s1),
		.interval (interval_q),
		.emit     (emit),
		.ev       (dec_ev)
	);

	assign push = step && emit;

	// output register
	ted_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_ev   (dec_ev),
		.space     (space),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_ev    (out_ev)
	);

	assign event_kind   = out_ev.kind;
	assign key_code     = out_ev.code;
	assign mouse_button = out_ev.button;
	assign mouse_x      = out_ev.x;
	assign mouse_y      = out_ev.y;

	// checks
	a_mouse_no_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (event_kind == KIND_MOUSE) |-> key_code == '0)
		else $error("mouse event carries a key code");

	a_key_no_mouse: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (event_kind == KIND_KEY) |->
		(mouse_button == '0) && (mouse_x == '0) && (mouse_y == '0))
		else $error("key event carries mouse fields");

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> valid_s1 && out_valid && !out_ready)
		else $error("input stalled without a full pipeline");

	a_blocked_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		step && focus_s1 |-> !push)
		else $error("event pushed while focus held elsewhere");

	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !push |=> !out_valid)
		else $error("output stayed valid after being taken");

endmodule

[sim/terminal_escape_and_mouse_decoder_unit_tb.sv]
// testbench for the terminal escape and sgr mouse decoder: directed table, then random
// byte streams checked against a behavioral decoder kept in this file
// depends on ted_pkg and terminal_escape_and_mouse_decoder_unit
module terminal_escape_and_mouse_decoder_unit_tb import ted_pkg::*;;

	timeunit 1ns;
	timeprecision 1ps;

	// parser phases of the behavioral decoder
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ESC1,
		ST_ESC_BR,
		ST_ESC_NB,
		ST_BTN,
		ST_X,
		ST_Y
	} parse_phase_t;

	// one directed word: byte, focus flag, and a typed-in event where one is obvious
	typedef struct packed {
		logic [BYTE_W-1:0] b;
		logic              f;
		logic              typed;
		ted_event_t        ev;
	} stim_row_t;

	localparam int N_DIRECTED = 25;

	localparam stim_row_t DIRECTED [0:N_DIRECTED-1] = '{
		'{8'h61,            1'b0, 1'b1, '{KIND_KEY, 10'd97, 8'd0, 16'd0, 16'd0}},
		'{CH_NUL,           1'b0, 1'b0, '0},
		'{8'hff,            1'b0, 1'b1, '{KIND_KEY, 10'd255, 8'd0, 16'd0, 16'd0}},
		'{8'h03,            1'b0, 1'b1, '{KIND_KEY, 10'd3, 8'd0, 16'd0, 16'd0}},
		'{CH_ESC,           1'b0, 1'b0, '0},
		'{CH_LBRACK,        1'b0, 1'b0, '0},
		'{CH_UP,            1'b0, 1'b1, '{KIND_KEY, KEY_UP, 8'd0, 16'd0, 16'd0}},
		'{CH_ESC,           1'b0, 1'b0, '0},
		'{CH_LBRACK,        1'b0, 1'b0, '0},
		'{CH_LEFT,          1'b0, 1'b1, '{KIND_KEY, KEY_LEFT, 8'd0, 16'd0, 16'd0}},
		'{CH_ESC,           1'b0, 1'b0, '0},
		'{8'h5a,            1'b0, 1'b0, '0},
		'{8'h51,            1'b0, 1'b1, '{KIND_KEY, KEY_ESC, 8'd0, 16'd0, 16'd0}},
		'{8'h6b,            1'b1, 1'b0, '0},
		'{CH_ESC,           1'b0, 1'b0, '0},
		'{CH_LBRACK,        1'b0, 1'b0, '0},
		'{CH_LT,            1'b0, 1'b0, '0},
		'{CH_NINE,          1'b0, 1'b0, '0},
		'{CH_NINE,          1'b0, 1'b0, '0},
		'{CH_NINE,          1'b0, 1'b0, '0},
		'{CH_SEMI,          1'b0, 1'b0, '0},
		'{CH_ZERO + 8'd1,   1'b0, 1'b0, '0},
		'{CH_SEMI,          1'b0, 1'b0, '0},
		'{CH_ZERO + 8'd2,   1'b0, 1'b0, '0},
		'{CH_PRESS,         1'b0, 1'b1, '{KIND_MOUSE, 10'd0, 8'd255, 16'd1, 16'd2}}
	};

	logic                  clk;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_ready;
	logic [BYTE_W-1:0]     rx_byte;
	logic [TIME_W-1:0]     now_ms;
	logic                  focus_elsewhere;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [INTERVAL_W-1:0] cfg_data;
	logic                  out_valid;
	logic                  out_ready;
	logic                  event_kind;
	logic [CODE_W-1:0]     key_code;
	logic [OUT_BTN_W-1:0]  mouse_button;
	logic [OUT_XY_W-1:0]   mouse_x;
	logic [OUT_XY_W-1:0]   mouse_y;

	terminal_escape_and_mouse_decoder_unit i_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.rx_byte         (rx_byte),
		.now_ms          (now_ms),
		.focus_elsewhere (focus_elsewhere),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_data        (cfg_data),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.event_kind      (event_kind),
		.key_code        (key_code),
		.mouse_button    (mouse_button),
		.mouse_x         (mouse_x),
		.mouse_y         (mouse_y)
	);

	// behavioral decoder state
	parse_phase_t            ph;
	logic [BUTTON_WIDTH-1:0] acc_btn;
	logic [COORD_WIDTH-1:0]  acc_x;
	logic [COORD_WIDTH-1:0]  acc_y;
	logic [BUTTON_WIDTH-1:0] sent_btn;
	logic [COORD_WIDTH-1:0]  sent_x;
	logic [COORD_WIDTH-1:0]  sent_y;
	logic                    sent_any;
	logic [TIME_W-1:0]       sent_ms;
	logic [INTERVAL_W-1:0]   move_gap_ms;

	ted_event_t        event_q[$];
	logic [BYTE_W-1:0] seq_bytes[$];
	logic [TIME_W-1:0] ms_now;
	int                error_count;
	int                random_bytes;
	int                hold_request;
	bit                source_busy;
	bit                sink_busy;
	longint unsigned   gen_btn;
	longint unsigned   gen_x;
	longint unsigned   gen_y;

	// clock
	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	// acc * 10 + digit, clamped to an all-ones value of the given width
	function automatic logic [31:0] add_digit(logic [31:0] acc, logic [BYTE_W-1:0] c,
			int width);
		longint unsigned v;
		longint unsigned top;
		top = (64'd1 << width) - 64'd1;
		v = longint'(acc) * 10 + longint'(c - CH_ZERO);
		if (v > top) begin
			v = top;
		end
		return v[31:0];
	endfunction

	// advance the decoder by one byte, returns 1 when an event comes out
	function automatic bit decode_byte(logic [BYTE_W-1:0] c, logic [TIME_W-1:0] t,
			logic blocked, output ted_event_t ev);
		bit                is_digit;
		bit                key_out;
		logic [CODE_W-1:0] code;
		ev = '0;
		key_out = 1'b0;
		code = '0;
		is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
		case (ph)
			ST_ESC1: begin
				if (c == CH_LBRACK) begin
					ph = ST_ESC_BR;
				end else begin
					ph = ST_ESC_NB;
				end
			end
			ST_ESC_BR: begin
				ph = ST_IDLE;
				if (c == CH_LT) begin
					acc_btn = '0;
					acc_x = '0;
					acc_y = '0;
					ph = ST_BTN;
				end else begin
					key_out = 1'b1;
					case (c)
						CH_UP:    code = KEY_UP;
						CH_DOWN:  code = KEY_DOWN;
						CH_RIGHT: code = KEY_RIGHT;
						CH_LEFT:  code = KEY_LEFT;
						default:  code = KEY_ESC;
					endcase
				end
			end
			ST_ESC_NB: begin
				ph = ST_IDLE;
				key_out = 1'b1;
				code = KEY_ESC;
			end
			ST_BTN: begin
				if (c == CH_SEMI) begin
					ph = ST_X;
				end else if (is_digit) begin
					acc_btn = BUTTON_WIDTH'(add_digit(32'(acc_btn), c, BUTTON_WIDTH));
				end
			end
			ST_X: begin
				if (c == CH_SEMI) begin
					ph = ST_Y;
				end else if (is_digit) begin
					acc_x = COORD_WIDTH'(add_digit(32'(acc_x), c, COORD_WIDTH));
				end
			end
			ST_Y: begin
				if (c == CH_PRESS || c == CH_REL) begin
					// report done: filter on button change and move interval
					ph = ST_IDLE;
					if (blocked) begin
						return 1'b0;
					end
					if (sent_any && acc_btn == sent_btn) begin
						if (acc_x == sent_x && acc_y == sent_y) begin
							return 1'b0;
						end
						if ((t - sent_ms) < {16'd0, move_gap_ms}) begin
							return 1'b0;
						end
					end
					sent_btn = acc_btn;
					sent_x = acc_x;
					sent_y = acc_y;
					sent_any = 1'b1;
					sent_ms = t;
					ev.kind = KIND_MOUSE;
					ev.button = OUT_BTN_W'(acc_btn);
					ev.x = OUT_XY_W'(acc_x);
					ev.y = OUT_XY_W'(acc_y);
					return 1'b1;
				end else if (is_digit) begin
					acc_y = COORD_WIDTH'(add_digit(32'(acc_y), c, COORD_WIDTH));
				end
			end
			default: begin
				ph = ST_IDLE;
				if (c == CH_ESC) begin
					ph = ST_ESC1;
				end else if (c != CH_NUL) begin
					key_out = 1'b1;
					code = CODE_W'(c);
				end
			end
		endcase
		if (key_out && !blocked) begin
			ev.kind = KIND_KEY;
			ev.code = code;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic void check_field(string name, longint unsigned want,
			longint unsigned got);
		if (want != got) begin
			$display("%0t: %s expected %0d, got %0d", $time, name, want, got);
			error_count++;
		end
	endfunction

	// a byte that is neither a digit nor a separator nor a terminator
	function automatic logic [BYTE_W-1:0] junk_byte();
		logic [BYTE_W-1:0] c;
		do begin
			c = BYTE_W'($urandom_range(0, 255));
		end while ((c >= CH_ZERO && c <= CH_NINE) || c == CH_SEMI || c == CH_PRESS
			|| c == CH_REL);
		return c;
	endfunction

	// decimal digits of v, with optional leading zeros and scattered junk
	function automatic void push_decimal(longint unsigned v, int zeros);
		logic [BYTE_W-1:0] digits[$];
		repeat (zeros) digits.push_back(CH_ZERO);
		do begin
			digits.insert(zeros, CH_ZERO + BYTE_W'(v % 10));
			v = v / 10;
		end while (v != 0);
		foreach (digits[i]) begin
			if ($urandom_range(0, 99) < 5) begin
				seq_bytes.push_back(junk_byte());
			end
			seq_bytes.push_back(digits[i]);
		end
	endfunction

	function automatic longint unsigned next_coord(longint unsigned cur);
		int r;
		r = $urandom_range(0, 99);
		if (r < 40) begin
			return cur;
		end
		if (r < 80) begin
			if (cur > 300) begin
				return $urandom_range(1, 300);
			end
			return cur + $urandom_range(1, 3);
		end
		if (r < 92) begin
			return $urandom_range(0, 65535);
		end
		return $urandom_range(65536, 9999999);
	endfunction

	function automatic longint unsigned next_button(longint unsigned cur);
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) begin
			return cur;
		end
		if (r < 85) begin
			case ($urandom_range(0, 5))
				0:       return 0;
				1:       return 1;
				2:       return 2;
				3:       return 32;
				4:       return 35;
				default: return 64;
			endcase
		end
		if (r < 95) begin
			return $urandom_range(0, 255);
		end
		return $urandom_range(256, 99999);
	endfunction

	// offer one word on the input channel and record what it should produce
	task automatic offer_byte(logic [BYTE_W-1:0] b, logic f, logic typed,
			ted_event_t typed_ev);
		int         gap;
		bit         has;
		ted_event_t pred;
		gap = source_busy ? $urandom_range(0, 16) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		rx_byte <= b;
		now_ms <= ms_now;
		focus_elsewhere <= f;
		do @(posedge clk); while (!in_ready);
		has = decode_byte(b, ms_now, f, pred);
		if (typed) begin
			event_q.push_back(typed_ev);
		end else if (has) begin
			event_q.push_back(pred);
		end
		random_bytes++;
		if ($urandom_range(0, 24) == 0) begin
			source_busy = !source_busy;
		end
	endtask

	// stop sending and let every pending event and the pipeline drain
	task automatic drain_events();
		in_valid <= 1'b0;
		while (event_q.size() != 0) @(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic write_move_gap(logic [INTERVAL_W-1:0] v);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		move_gap_ms = v;
	endtask

	// one random burst: mouse report, arrow, bare escape or plain bytes
	task automatic play_sequence();
		int r;
		int k;
		seq_bytes.delete();
		r = $urandom_range(0, 99);
		if (r < 50) begin
			seq_bytes.push_back(CH_ESC);
			seq_bytes.push_back(CH_LBRACK);
			seq_bytes.push_back(CH_LT);
			gen_btn = next_button(gen_btn);
			push_decimal(gen_btn, ($urandom_range(0, 9) == 0) ? $urandom_range(1, 3) : 0);
			seq_bytes.push_back(CH_SEMI);
			gen_x = next_coord(gen_x);
			push_decimal(gen_x, ($urandom_range(0, 9) == 0) ? $urandom_range(1, 3) : 0);
			seq_bytes.push_back(CH_SEMI);
			gen_y = next_coord(gen_y);
			push_decimal(gen_y, ($urandom_range(0, 9) == 0) ? $urandom_range(1, 3) : 0);
			if ($urandom_range(0, 99) < 95) begin
				seq_bytes.push_back($urandom_range(0, 1) ? CH_PRESS : CH_REL);
			end
			// broken report: cut off somewhere
			if ($urandom_range(0, 99) < 4) begin
				k = $urandom_range(1, seq_bytes.size() - 1);
				repeat (k) void'(seq_bytes.pop_back());
			end
		end else if (r < 65) begin
			seq_bytes.push_back(CH_ESC);
			seq_bytes.push_back(CH_LBRACK);
			case ($urandom_range(0, 4))
				0:       seq_bytes.push_back(CH_UP);
				1:       seq_bytes.push_back(CH_DOWN);
				2:       seq_bytes.push_back(CH_RIGHT);
				3:       seq_bytes.push_back(CH_LEFT);
				default: seq_bytes.push_back(BYTE_W'($urandom_range(0, 255)));
			endcase
		end else if (r < 75) begin
			seq_bytes.push_back(CH_ESC);
			seq_bytes.push_back(BYTE_W'($urandom_range(0, 255)));
			seq_bytes.push_back(BYTE_W'($urandom_range(0, 255)));
		end else begin
			repeat ($urandom_range(1, 4)) seq_bytes.push_back(BYTE_W'($urandom_range(0, 255)));
		end
		// time between bursts: mostly short, sometimes long, rarely anything
		r = $urandom_range(0, 99);
		if (r < 80) begin
			ms_now += $urandom_range(0, 20);
		end else if (r < 96) begin
			ms_now += $urandom_range(20, 400);
		end else begin
			ms_now += $urandom;
		end
		foreach (seq_bytes[i]) begin
			ms_now += $urandom_range(0, 2);
			offer_byte(seq_bytes[i], $urandom_range(0, 99) < 8, 1'b0, '0);
		end
	endtask

	// stimulus and phase control
	initial begin : stimulus
		logic [INTERVAL_W-1:0] gap_value;
		arst_n = 1'b0;
		in_valid = 1'b0;
		rx_byte = '0;
		now_ms = '0;
		focus_elsewhere = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		out_ready = 1'b0;
		error_count = 0;
		random_bytes = 0;
		hold_request = 0;
		source_busy = 1'b1;
		sink_busy = 1'b1;
		ms_now = '0;
		gen_btn = 0;
		gen_x = 10;
		gen_y = 10;
		ph = ST_IDLE;
		acc_btn = '0;
		acc_x = '0;
		acc_y = '0;
		sent_btn = '0;
		sent_x = '0;
		sent_y = '0;
		sent_any = 1'b0;
		sent_ms = '0;
		move_gap_ms = INTERVAL_RESET;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		for (int i = 0; i < N_DIRECTED; i++) begin
			ms_now += 1;
			offer_byte(DIRECTED[i].b, DIRECTED[i].f, DIRECTED[i].typed, DIRECTED[i].ev);
		end

		// random phases over several move intervals, the first at the reset value
		for (int p = 0; p < 5; p++) begin
			drain_events();
			case (p)
				1:       gap_value = '0;
				2:       gap_value = '1;
				3:       gap_value = INTERVAL_W'($urandom_range(0, 65535));
				4:       gap_value = INTERVAL_W'($urandom_range(1, 40));
				default: gap_value = INTERVAL_RESET;
			endcase
			if (p != 0) begin
				write_move_gap(gap_value);
			end
			// start one phase just short of the time wrap
			ms_now = (p == 1) ? 32'hffff_ff80 : $urandom;
			if (p == 2) begin
				hold_request = 300;
			end
			random_bytes = 0;
			while (random_bytes < 100) play_sequence();
		end
		drain_events();

		if (error_count == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

	// output side: random stalls, one long hold, check each event in order
	initial begin : event_sink
		int         stall;
		ted_event_t want;
		wait (arst_n === 1'b1);
		forever begin
			if (hold_request > 0) begin
				stall = hold_request;
				hold_request = 0;
			end else if (sink_busy) begin
				stall = $urandom_range(0, 16);
			end else begin
				stall = 0;
			end
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			if (event_q.size() == 0) begin
				$display("%0t: event expected none, got kind %0d code %0d button %0d x %0d y %0d",
					$time, event_kind, key_code, mouse_button, mouse_x, mouse_y);
				error_count++;
			end else begin
				want = event_q.pop_front();
				check_field("event_kind", want.kind, event_kind);
				check_field("key_code", want.code, key_code);
				check_field("mouse_button", want.button, mouse_button);
				check_field("mouse_x", want.x, mouse_x);
				check_field("mouse_y", want.y, mouse_y);
			end
			if ($urandom_range(0, 19) == 0) begin
				sink_busy = !sink_busy;
			end
		end
	end

	// run limit
	initial begin : watchdog
		#4_000_000;
		$display("Mismatches found");
		$finish;
	end

endmodule

[filelist.f]
design/ted_pkg.sv
design/ted_decode.sv
design/ted_out_reg.sv
design/terminal_escape_and_mouse_decoder_unit.sv
sim/terminal_escape_and_mouse_decoder_unit_tb.sv
